/* rtl/clhp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clhp_pkg;

  // Configured capture link types
  localparam logic [15:0] LinkLoopback = 16'd0;
  localparam logic [15:0] LinkRawIp    = 16'd101;
  localparam logic [15:0] LinkCookedV1 = 16'd113;
  localparam logic [15:0] LinkCookedV2 = 16'd276;

  // Record status codes
  localparam logic [1:0] StatusOk          = 2'd0;
  localparam logic [1:0] StatusTooShort    = 2'd1;
  localparam logic [1:0] StatusUnsupported = 2'd2;

  // Payload kinds
  localparam logic [1:0] KindUnknown   = 2'd0;
  localparam logic [1:0] KindIpv4      = 2'd1;
  localparam logic [1:0] KindIpv6      = 2'd2;
  localparam logic [1:0] KindEthertype = 2'd3;

  // Header lengths in bytes
  localparam logic [4:0] HdrLoopback = 5'd4;
  localparam logic [4:0] HdrRawIp    = 5'd0;
  localparam logic [4:0] HdrCookedV1 = 5'd16;
  localparam logic [4:0] HdrCookedV2 = 5'd20;

  localparam int unsigned StoreDepth = 20;
  localparam int unsigned StoreIdxW  = 5;
  localparam logic [3:0]  AddrLenMax = 4'd8;

  // Loopback address families
  localparam logic [31:0] FamInet    = 32'd2;
  localparam logic [31:0] FamInet6A  = 32'd10;
  localparam logic [31:0] FamInet6B  = 32'd24;
  localparam logic [31:0] FamInet6C  = 32'd28;
  localparam logic [31:0] FamInet6D  = 32'd30;

  // IP version nibbles
  localparam logic [3:0] IpVer4 = 4'd4;
  localparam logic [3:0] IpVer6 = 4'd6;

  typedef logic [StoreDepth-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  payload_kind;
    logic [4:0]  header_length;
    logic [15:0] payload_length;
    logic [15:0] ethertype;
    logic [15:0] packet_direction;
    logic [15:0] hardware_type;
    logic [3:0]  address_length;
    logic [63:0] link_address;
    logic [31:0] interface_index;
    logic [31:0] loopback_family;
  } rec_t;

  function automatic logic [1:0] family_kind(input logic [31:0] fam);
    logic [1:0] k;
    k = KindUnknown;
    if (fam == FamInet) begin
      k = KindIpv4;
    end else if (fam == FamInet6A || fam == FamInet6B ||
                 fam == FamInet6C || fam == FamInet6D) begin
      k = KindIpv6;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/clhp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module clhp_front
  import clhp_pkg::*;
#(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                frame_last_i,
  input  wire logic                q_ready_i,
  output logic                     push_o,
  output hdr_bytes_t               hdr_o,
  output logic [LEN_BITS-1:0]      len_o
);

  localparam logic [LEN_BITS-1:0] MaxCount = {LEN_BITS{1'b1}};

  logic [LEN_BITS-1:0] count_q, count_d;
  hdr_bytes_t          store_q;
  logic                accept;
  logic                in_store;
  logic [LEN_BITS-1:0] len_next;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign in_store   = count_q < LEN_BITS'(StoreDepth);
  assign len_next   = (count_q == MaxCount) ? count_q : count_q + 1'b1;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = frame_last_i ? '0 : len_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // header bytes, stale beyond the current count
  always_ff @(posedge clk_i) begin
    if (accept && in_store) begin
      store_q[count_q[StoreIdxW-1:0]] <= data_byte_i;
    end
  end

  // snapshot with the final beat merged in
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      hdr_o[i] = (in_store && count_q[StoreIdxW-1:0] == StoreIdxW'(i)) ?
                 data_byte_i : store_q[i];
    end
  end

  assign push_o = accept && frame_last_i;
  assign len_o  = len_next;

endmodule

`default_nettype wire

/* rtl/clhp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module clhp_queue #(
  parameter int unsigned WIDTH = 176
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rdata_o,
  input  wire logic             pop_ready_i
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            fill_q, fill_d;
  logic                  pop;

  assign ready_o = fill_q != 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/clhp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module clhp_back
  import clhp_pkg::*;
#(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [15:0]         link_code_i,
  input  wire logic                q_valid_i,
  output logic                     q_ready_o,
  input  wire hdr_bytes_t          hdr_i,
  input  wire logic [LEN_BITS-1:0] len_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rec_t                     rec_o
);

  localparam int unsigned DiffW = (LEN_BITS > 16) ? LEN_BITS : 16;

  rec_t              rec_q, rec_d;
  logic              valid_q;
  logic              load;
  logic [4:0]        hdr_len;
  logic [DiffW-1:0]  diff;
  logic [15:0]       pay_len;
  logic [31:0]       fam_le, fam_be;
  logic [1:0]        kind_le, kind_be;
  logic [15:0]       al_v1;
  logic [7:0]        al_v2;

  assign q_ready_o = !valid_q || out_ready_i;
  assign load      = q_valid_i && q_ready_o;

  always_comb begin
    unique case (link_code_i)
      LinkLoopback: hdr_len = HdrLoopback;
      LinkCookedV1: hdr_len = HdrCookedV1;
      LinkCookedV2: hdr_len = HdrCookedV2;
      default:      hdr_len = HdrRawIp;
    endcase
  end

  assign diff    = DiffW'(len_i) - DiffW'(hdr_len);
  assign pay_len = (diff > DiffW'(16'hFFFF)) ? 16'hFFFF : diff[15:0];

  assign fam_le  = {hdr_i[3], hdr_i[2], hdr_i[1], hdr_i[0]};
  assign fam_be  = {hdr_i[0], hdr_i[1], hdr_i[2], hdr_i[3]};
  assign kind_le = family_kind(fam_le);
  assign kind_be = family_kind(fam_be);
  assign al_v1   = {hdr_i[4], hdr_i[5]};
  assign al_v2   = hdr_i[11];

  always_comb begin
    rec_d = '0;
    unique case (link_code_i)
      LinkLoopback: begin
        if (len_i < LEN_BITS'(HdrLoopback)) begin
          rec_d.status = StatusTooShort;
        end else begin
          rec_d.header_length  = HdrLoopback;
          rec_d.payload_length = pay_len;
          if (kind_le == KindUnknown && kind_be != KindUnknown) begin
            rec_d.payload_kind    = kind_be;
            rec_d.loopback_family = fam_be;
          end else begin
            rec_d.payload_kind    = kind_le;
            rec_d.loopback_family = fam_le;
          end
        end
      end
      LinkRawIp: begin
        rec_d.header_length  = HdrRawIp;
        rec_d.payload_length = pay_len;
        if (hdr_i[0][7:4] == IpVer4) begin
          rec_d.payload_kind = KindIpv4;
        end else if (hdr_i[0][7:4] == IpVer6) begin
          rec_d.payload_kind = KindIpv6;
        end
      end
      LinkCookedV1: begin
        if (len_i < LEN_BITS'(HdrCookedV1)) begin
          rec_d.status = StatusTooShort;
        end else begin
          rec_d.payload_kind     = KindEthertype;
          rec_d.header_length    = HdrCookedV1;
          rec_d.payload_length   = pay_len;
          rec_d.ethertype        = {hdr_i[14], hdr_i[15]};
          rec_d.packet_direction = {hdr_i[0], hdr_i[1]};
          rec_d.hardware_type    = {hdr_i[2], hdr_i[3]};
          rec_d.address_length   = (al_v1 > 16'(AddrLenMax)) ? AddrLenMax : al_v1[3:0];
          rec_d.link_address     = {hdr_i[6], hdr_i[7], hdr_i[8], hdr_i[9],
                                    hdr_i[10], hdr_i[11], hdr_i[12], hdr_i[13]};
        end
      end
      LinkCookedV2: begin
        if (len_i < LEN_BITS'(HdrCookedV2)) begin
          rec_d.status = StatusTooShort;
        end else begin
          rec_d.payload_kind     = KindEthertype;
          rec_d.header_length    = HdrCookedV2;
          rec_d.payload_length   = pay_len;
          rec_d.ethertype        = {hdr_i[0], hdr_i[1]};
          rec_d.packet_direction = {8'h00, hdr_i[10]};
          rec_d.hardware_type    = {hdr_i[8], hdr_i[9]};
          rec_d.address_length   = (al_v2 > 8'(AddrLenMax)) ? AddrLenMax : al_v2[3:0];
          rec_d.link_address     = {hdr_i[12], hdr_i[13], hdr_i[14], hdr_i[15],
                                    hdr_i[16], hdr_i[17], hdr_i[18], hdr_i[19]};
          rec_d.interface_index  = {hdr_i[4], hdr_i[5], hdr_i[6], hdr_i[7]};
        end
      end
      default: begin
        rec_d.status = StatusUnsupported;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= rec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

/* rtl/capture_link_header_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Payload
// in        in   in_valid_i/in_ready_o   data_byte_i, frame_last_i (one byte per beat)
// out       out  out_valid_o/out_ready_i decoded link header record, one per frame
// cfg       in   cfg_we_i                cfg_wdata_i -> link code
//
// One byte beat per cycle while the frame queue has room; the byte counter and header
// store update in the accepting cycle. A frame's record becomes valid after the queue
// write, then the decode into the output register; a stalled output holds it queued.
// Reset clears the count, queue pointers, output valid and link code (loopback).
// A two-entry queue of frame snapshots parts the byte side from the decoder,
// so a stalled output blocks input only once both entries are held.

module capture_link_header_parser
  import clhp_pkg::*;
#(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [1:0]       payload_kind_o,
  output logic [4:0]       header_length_o,
  output logic [15:0]      payload_length_o,
  output logic [15:0]      ethertype_o,
  output logic [15:0]      packet_direction_o,
  output logic [15:0]      hardware_type_o,
  output logic [3:0]       address_length_o,
  output logic [63:0]      link_address_o,
  output logic [31:0]      interface_index_o,
  output logic [31:0]      loopback_family_o
);

  localparam int unsigned EntryW = $bits(hdr_bytes_t) + LEN_BITS;

  logic [15:0]         link_code_q;
  logic                q_ready, push, q_valid, q_pop_ready;
  hdr_bytes_t          f_hdr, b_hdr;
  logic [LEN_BITS-1:0] f_len, b_len;
  logic [EntryW-1:0]   q_rdata;
  rec_t                rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_code_q <= LinkLoopback;
    end else if (cfg_we_i) begin
      link_code_q <= cfg_wdata_i;
    end
  end

  clhp_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .hdr_o        (f_hdr),
    .len_o        (f_len)
  );

  // frame snapshot: header bytes above, length below
  clhp_queue #(.WIDTH(EntryW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     ({f_hdr, f_len}),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .rdata_o     (q_rdata),
    .pop_ready_i (q_pop_ready)
  );

  assign b_hdr = q_rdata[EntryW-1:LEN_BITS];
  assign b_len = q_rdata[LEN_BITS-1:0];

  clhp_back #(.LEN_BITS(LEN_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_code_i (link_code_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_pop_ready),
    .hdr_i       (b_hdr),
    .len_i       (b_len),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec)
  );

  assign status_o           = rec.status;
  assign payload_kind_o     = rec.payload_kind;
  assign header_length_o    = rec.header_length;
  assign payload_length_o   = rec.payload_length;
  assign ethertype_o        = rec.ethertype;
  assign packet_direction_o = rec.packet_direction;
  assign hardware_type_o    = rec.hardware_type;
  assign address_length_o   = rec.address_length;
  assign link_address_o     = rec.link_address;
  assign interface_index_o  = rec.interface_index;
  assign loopback_family_o  = rec.loopback_family;

endmodule

`default_nettype wire
